FILE: hw/rtl/positional_list_insert_remove_defines.svh
// Assertion macros shared by the RTL.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define PLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off while in reset.
`define PLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/pli_pkg.sv
package pli_pkg;

	// operation codes
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_AT    = 3'd2;
	localparam logic [2:0] OP_REM_FRONT = 3'd3;
	localparam logic [2:0] OP_REM_BACK  = 3'd4;
	localparam logic [2:0] OP_REM_AT    = 3'd5;
	localparam logic [2:0] OP_READ_AT   = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [6:0]  position;
		logic [31:0] entry_value;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [1:0]  status;
		logic [6:0]  entry_count;
	} out_beat_t;

endpackage

FILE: hw/rtl/pli_ram.sv
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/positional_list_insert_remove.sv
// Channel | Signals                       | Beat contents
// --------+-------------------------------+------------------------------------------
// in      | in_valid / in_ready / in_data  | operation, position, entry_value
// out     | out_valid / out_ready / out_data | result_value, status, entry_count
//
// One operation at a time: accept, decode, then deliver. Each entry moved by a shift takes
// a RAM read, then a write back one place over, on the single RAM port pair. An insert
// shifts the entries from its position up; a remove shifts the entries above it down.
// A read at a position, a failed operation and an unknown operation move no entries.
// Reset clears the count, the sequencer and the output valid; the entry RAM is never cleared.
// A result waiting on out_ready holds the sequencer in its finish step; no new beat is
// taken while that result waits.
`include "positional_list_insert_remove_defines.svh"

module positional_list_insert_remove
	import pli_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	// address, count, index and compare widths
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 1;
	localparam int XW = (IW > 7) ? IW : 7;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_DECODE   = 10'b0000000010,
		S_UP_RD    = 10'b0000000100,
		S_UP_WR    = 10'b0000001000,
		S_PUT      = 10'b0000010000,
		S_GET_RD   = 10'b0000100000,
		S_GET_WAIT = 10'b0001000000,
		S_DN_RD    = 10'b0010000000,
		S_DN_WR    = 10'b0100000000,
		S_FINISH   = 10'b1000000000
	} state_t;

	state_t          state_q;
	logic [2:0]      op_q;
	logic [6:0]      pos_q;
	logic [31:0]     val_q;
	logic [CW-1:0]   occ_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   pos_eff_q;
	logic [31:0]     res_q;
	logic [1:0]      st_q;
	logic            out_valid_q;
	out_beat_t       out_data_q;

	// RAM port signals
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [31:0]     ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [31:0]     ram_rdata;

	// decode
	logic [XW-1:0]   occ_x;
	logic [XW-1:0]   eff_x;
	logic            is_ins;
	logic            is_rem;
	logic            is_read;
	logic [1:0]      dec_st;

	// shared index unit: one adder, stepping down for the insert shift, up otherwise
	logic            step_dn;
	logic [IW-1:0]   nxt;
	logic [XW-1:0]   nxt_x;
	logic [XW-1:0]   count_x;

	assign step_dn = (state_q == S_UP_RD) || (state_q == S_UP_WR);
	assign nxt     = step_dn ? ({1'b0, idx_q} - IW'(1)) : ({1'b0, idx_q} + IW'(1));
	assign nxt_x   = XW'(nxt);

	assign occ_x   = XW'(occ_q);
	assign count_x = XW'(occ_q);

	always_comb begin
		is_ins  = op_q inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT};
		is_rem  = op_q inside {OP_REM_FRONT, OP_REM_BACK, OP_REM_AT};
		is_read = (op_q == OP_READ_AT);
		case (op_q)
			OP_INS_FRONT, OP_REM_FRONT: eff_x = '0;
			OP_INS_BACK:                eff_x = occ_x;
			OP_REM_BACK:                eff_x = occ_x - XW'(1);
			OP_INS_AT, OP_REM_AT, OP_READ_AT: eff_x = XW'(pos_q);
			default:                    eff_x = '0;
		endcase
		dec_st = ST_OK;
		if (is_ins) begin
			// full wins over a bad position
			if (occ_x >= XW'(CAPACITY)) begin
				dec_st = ST_FULL;
			end else if (eff_x > occ_x) begin
				dec_st = ST_BADPOS;
			end
		end else if (is_rem || is_read) begin
			if (occ_q == '0) begin
				dec_st = ST_EMPTY;
			end else if (eff_x >= occ_x) begin
				dec_st = ST_BADPOS;
			end
		end
	end

	// RAM port muxing
	always_comb begin
		ram_we    = (state_q == S_UP_WR) || (state_q == S_PUT) || (state_q == S_DN_WR);
		ram_waddr = (state_q == S_PUT) ? pos_eff_q : idx_q;
		ram_wdata = (state_q == S_PUT) ? val_q : ram_rdata;
		ram_raddr = ((state_q == S_UP_RD) || (state_q == S_DN_RD)) ? nxt[AW-1:0] : pos_eff_q;
	end

	pli_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loads from the finish step, empties on a taken beat
			if ((state_q == S_FINISH) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (dec_st != ST_OK) begin
						state_q <= S_FINISH;
					end else if (is_ins) begin
						state_q <= (eff_x == occ_x) ? S_PUT : S_UP_RD;
					end else if (is_rem || is_read) begin
						state_q <= S_GET_RD;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_UP_RD: state_q <= S_UP_WR;
				S_UP_WR: begin
					state_q <= (nxt_x == XW'(pos_eff_q)) ? S_PUT : S_UP_RD;
				end
				S_PUT: begin
					occ_q   <= occ_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_GET_RD: state_q <= S_GET_WAIT;
				S_GET_WAIT: begin
					state_q <= is_read ? S_FINISH : S_DN_RD;
				end
				S_DN_RD: begin
					if (nxt_x < occ_x) begin
						state_q <= S_DN_WR;
					end else begin
						occ_q   <= occ_q - CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_DN_WR: state_q <= S_DN_RD;
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q  <= in_data.operation;
					pos_q <= in_data.position;
					val_q <= in_data.entry_value;
				end
			end
			S_DECODE: begin
				st_q      <= dec_st;
				res_q     <= '0;
				pos_eff_q <= eff_x[AW-1:0];
				idx_q     <= occ_q[AW-1:0];
			end
			S_UP_WR: idx_q <= nxt[AW-1:0];
			S_GET_WAIT: begin
				res_q <= ram_rdata;
				idx_q <= pos_eff_q;
			end
			S_DN_WR: idx_q <= nxt[AW-1:0];
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_data_q.result_value <= res_q;
					out_data_q.status       <= st_q;
					out_data_q.entry_count  <= count_x[6:0];
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// count never passes capacity
	`PLI_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CW'(CAPACITY))
	// count moves only on the final insert write or the end of a remove shift
	`PLI_ASSERT_NXT(a_occ_hold, clk, arst_n,
		(state_q != S_PUT) && (state_q != S_DN_RD), $stable(occ_q))
	// failed operations return no value
	`PLI_ASSERT_IMP(a_fail_zero, clk, arst_n,
		out_valid && (out_data.status != ST_OK), out_data.result_value == '0)
	// no store writes outside an operation
	`PLI_ASSERT_IMP(a_idle_nowr, clk, arst_n, state_q == S_IDLE, !ram_we)
	// full is only reported with the list at capacity
	`PLI_ASSERT_IMP(a_full_cap, clk, arst_n,
		(state_q == S_FINISH) && (st_q == ST_FULL), occ_q == CW'(CAPACITY))

endmodule

FILE: verif/testbench.sv
module testbench;
	import pli_pkg::*;

	// Sizing for the run. The slowest operation is a remove at the front of a full list,
	// which shifts every other entry down. Add the longest receiver stall and sender gap,
	// and the hold-off stretch still dominates everything else.
	localparam int LIST_CAPACITY   = 64;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT  = 4000;

	// The package names codes 0..6 only; 7 must come back as a harmless no-op.
	localparam logic [2:0] OP_UNDEFINED = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	// Shadow copy of the list, in order, front at index 0.
	logic [31:0] list_entries[$];
	out_beat_t   expected_results[$];

	// Shared flags between the stimulus tasks and the receiver process.
	bit idling_on;
	bit hold_off_req;
	bit hold_off_active;

	int error_count;
	int beats_sent;
	int results_checked;
	int full_rejects;
	int peak_count;

	positional_list_insert_remove #(
		.CAPACITY(LIST_CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// List predictor: applies one operation to the shadow list and
	// returns the result beat the block must produce for it.
	// ------------------------------------------------------------------
	function automatic out_beat_t apply_list_op(input in_beat_t beat);
		out_beat_t res;
		int        fill;
		int        slot;
		fill             = list_entries.size();
		res.result_value = '0;
		res.status       = ST_OK;
		case (beat.operation)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				if (beat.operation == OP_INS_FRONT)
					slot = 0;
				else if (beat.operation == OP_INS_BACK)
					slot = fill;
				else
					slot = beat.position;
				// full wins over a bad position
				if (fill >= LIST_CAPACITY) begin
					res.status = ST_FULL;
					full_rejects++;
				end else if (slot > fill) begin
					res.status = ST_BADPOS;
				end else begin
					list_entries.insert(slot, beat.entry_value);
				end
			end
			OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
				if (beat.operation == OP_REM_FRONT)
					slot = 0;
				else if (beat.operation == OP_REM_BACK)
					slot = (fill == 0) ? 0 : fill - 1;
				else
					slot = beat.position;
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else if (slot >= fill) begin
					res.status = ST_BADPOS;
				end else begin
					res.result_value = list_entries[slot];
					list_entries.delete(slot);
				end
			end
			OP_READ_AT: begin
				if (fill == 0)
					res.status = ST_EMPTY;
				else if (beat.position >= fill)
					res.status = ST_BADPOS;
				else
					res.result_value = list_entries[beat.position];
			end
			default: ;  // undefined code: nothing changes
		endcase
		fill            = list_entries.size();
		res.entry_count = fill[6:0];
		if (fill > peak_count)
			peak_count = fill;
		return res;
	endfunction

	// Mostly random words, with the all-zero and all-one patterns mixed in.
	function automatic logic [31:0] random_entry();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender: offers one beat, holds it until accepted, then records the
	// expected result. Random gaps come before the beat while idling is on.
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [2:0] op, input logic [6:0] pos,
			input logic [31:0] value);
		in_beat_t beat;
		int       gap;
		beat.operation   = op;
		beat.position    = pos;
		beat.entry_value = value;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge
		expected_results.push_back(apply_list_op(beat));
		beats_sent++;
	endtask

	// One random beat. ins_weight is the percentage of inserts; positions mostly
	// fall in 0..count so the shifts get exercised, the rest cover the whole field.
	task automatic send_random_op(input int ins_weight);
		logic [2:0] op;
		logic [6:0] pos;
		int         fill;
		int         pick;
		fill = list_entries.size();
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			op = OP_UNDEFINED;
		end else if (pick < 2 + ins_weight) begin
			case ($urandom_range(0, 2))
				0:       op = OP_INS_FRONT;
				1:       op = OP_INS_BACK;
				default: op = OP_INS_AT;
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0:       op = OP_REM_FRONT;
				1:       op = OP_REM_BACK;
				2:       op = OP_REM_AT;
				default: op = OP_READ_AT;
			endcase
		end
		if ($urandom_range(0, 9) < 8)
			pos = 7'($urandom_range(0, fill));
		else
			pos = 7'($urandom_range(0, 127));
		send_beat(op, pos, random_entry());
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
			results_checked, field, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Result checker: every accepted output beat is compared against the
	// oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat, value", out_data.result_value, 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.result_value !== want.result_value)
					report_mismatch("result_value", out_data.result_value,
						want.result_value);
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(out_data.entry_count),
						32'(want.entry_count));
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random ready bursts while idling is on, a long hold-off on
	// request, and ready held high otherwise.
	// ------------------------------------------------------------------
	initial begin : receiver
		int span;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_active = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req    = 1'b0;
				hold_off_active = 1'b0;
			end else if (idling_on && $urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (span) @(posedge clk);
			end else begin
				span = idling_on ? $urandom_range(1, 19) : 1;
				out_ready <= 1'b1;
				repeat (span) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run if neither channel moves a beat for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every remove and the read on an empty list, an insert past the end of an
	// empty list, and the undefined code.
	task automatic test_empty_list();
		send_beat(OP_REM_FRONT, 7'd0, 32'hDEAD_BEEF);
		send_beat(OP_REM_BACK, 7'd0, 32'h0);
		send_beat(OP_REM_AT, 7'd0, 32'h0);
		send_beat(OP_READ_AT, 7'd127, 32'h0);
		send_beat(OP_INS_AT, 7'd1, 32'h1234_5678);
		send_beat(OP_UNDEFINED, 7'd127, 32'hFFFF_FFFF);
	endtask

	// Each operation once on a short list, with field extremes and the
	// boundary positions: insert at the count appends, remove/read at the
	// count and at the top of the field are rejected.
	task automatic test_basic_ops();
		send_beat(OP_INS_FRONT, 7'd127, 32'hFFFF_FFFF);
		send_beat(OP_INS_BACK, 7'd0, 32'h0000_0000);
		send_beat(OP_INS_AT, 7'd1, 32'hA5A5_5A5A);
		send_beat(OP_INS_AT, 7'd3, 32'h5A5A_A5A5);   // position == count
		send_beat(OP_INS_AT, 7'd127, 32'h0BAD_0BAD);
		send_beat(OP_INS_AT, 7'd5, 32'h0BAD_0BAD);   // one past the count
		send_beat(OP_READ_AT, 7'd0, 32'h0);
		send_beat(OP_READ_AT, 7'd3, 32'h0);
		send_beat(OP_READ_AT, 7'd4, 32'h0);
		send_beat(OP_READ_AT, 7'd127, 32'h0);
		send_beat(OP_REM_AT, 7'd1, 32'h0);
		send_beat(OP_REM_AT, 7'd3, 32'h0);
		send_beat(OP_REM_AT, 7'd127, 32'h0);
		send_beat(OP_REM_FRONT, 7'd127, 32'h0);
		send_beat(OP_REM_BACK, 7'd0, 32'h0);
		send_beat(OP_UNDEFINED, 7'd0, 32'h0);
	endtask

	// Fill the list with random inserts, hit it with every insert flavor while
	// full (full must win over a bad position), then probe the last slot.
	task automatic test_full_list();
		int fill;
		while (list_entries.size() < LIST_CAPACITY) begin
			fill = list_entries.size();
			case ($urandom_range(0, 2))
				0:       send_beat(OP_INS_FRONT, 7'($urandom_range(0, 127)), random_entry());
				1:       send_beat(OP_INS_BACK, 7'($urandom_range(0, 127)), random_entry());
				default: send_beat(OP_INS_AT, 7'($urandom_range(0, fill)), random_entry());
			endcase
		end
		send_beat(OP_INS_FRONT, 7'd0, 32'h1111_1111);
		send_beat(OP_INS_BACK, 7'd0, 32'h2222_2222);
		send_beat(OP_INS_AT, 7'd0, 32'h3333_3333);
		send_beat(OP_INS_AT, 7'd127, 32'h4444_4444);
		send_beat(OP_READ_AT, 7'd63, 32'h0);
		send_beat(OP_READ_AT, 7'd64, 32'h0);
		send_beat(OP_REM_AT, 7'd64, 32'h0);
		send_beat(OP_REM_AT, 7'd0, 32'h0);          // longest shift down
		send_beat(OP_INS_AT, 7'd0, random_entry()); // longest shift up
		repeat (20) send_random_op(20);
	endtask

	// Random traffic in phases that lean toward growing or shrinking the list,
	// so the count sweeps between empty and full several times.
	task automatic test_random_ops(input int n_beats);
		int sent;
		int phase_len;
		int ins_weight;
		sent = 0;
		while (sent < n_beats) begin
			phase_len  = $urandom_range(40, 150);
			ins_weight = ($urandom_range(0, 1) == 0) ? 75 : 25;
			repeat (phase_len) begin
				if (sent < n_beats) begin
					send_random_op(ins_weight);
					sent++;
				end
			end
		end
	endtask

	// Receiver stops taking results for a long stretch while beats keep coming:
	// the block has to park its result and stall the input side.
	task automatic test_output_hold_off();
		// the last beat is already taken; stop offering it while we wait
		in_valid <= 1'b0;
		hold_off_req = 1'b1;
		wait (hold_off_active);
		@(posedge clk);
		repeat (30) send_random_op(50);
		wait (!hold_off_active);
	endtask

	// Last stretch with both sides always willing.
	task automatic test_back_to_back();
		idling_on = 1'b0;
		test_random_ops(150);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		idling_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random_ops(650);
		test_output_hold_off();
		test_random_ops(50);
		test_back_to_back();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// let anything stray come out before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d beats in, %0d results checked, %0d mismatches.",
			beats_sent, results_checked, error_count);
		$display("List peaked at %0d entries; %0d inserts rejected as full.",
			peak_count, full_rejects);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: positional_list_insert_remove.f
+incdir+hw/rtl
hw/rtl/pli_pkg.sv
hw/rtl/pli_ram.sv
hw/rtl/positional_list_insert_remove.sv
verif/testbench.sv
